FILE: design/ptr_pkg.sv
package ptr_pkg;

   localparam int NUM_STATES  = 64;
   localparam int NUM_ACTIONS = 8;
   localparam int TABLE_DEPTH = NUM_STATES * NUM_ACTIONS;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COL_W       = $clog2(NUM_ACTIONS);
   localparam int STATE_W     = 6;
   localparam int CFG_W       = 17;
   localparam int AIU_W       = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int PROD_W      = 50;
   localparam int ADD_W       = PROD_W - 16;
   localparam int SUM_W       = ADD_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_FACTOR    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARE_CHOSEN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARE_OTHERS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIONS_IN_USE = 2'd3;

   localparam logic [CFG_W-1:0] KEEP_FACTOR_RESET  = 17'd65536;
   localparam logic [CFG_W-1:0] SHARE_CHOSEN_RESET = 17'd62259;
   localparam logic [CFG_W-1:0] SHARE_OTHERS_RESET = 17'd3277;
   localparam logic [AIU_W-1:0] ACTIONS_RESET      = 4'd8;

   localparam logic CMD_REINFORCE = 1'b0;
   localparam logic CMD_READ      = 1'b1;

   localparam logic signed [SUM_W-1:0] SAT_HI = 35'sd2147483647;
   localparam logic signed [SUM_W-1:0] SAT_LO = -35'sd2147483648;

   typedef enum logic [3:0] {
      S_CLR,
      S_IDLE,
      S_CHK,
      S_DRD,
      S_DMUL,
      S_DWR,
      S_ADD0,
      S_ADD1,
      S_ADD2,
      S_RRD,
      S_RWR,
      S_ROUT
   } step_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_DECAY,
      MUL_CHOSEN,
      MUL_OTHER
   } mul_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_CLEAR,
      WR_DECAY,
      WR_ROW
   } wr_sel_type;

   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_SUM,
      OUT_RDATA
   } out_sel_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NOT_START,
      COND_NO_DECAY,
      COND_IDX_MORE,
      COND_BAD_STATE,
      COND_IS_READ,
      COND_COL_MORE
   } cond_type;

   typedef struct packed {
      logic        busy;
      logic        rd;
      logic        asel_row;
      mul_sel_type mul;
      logic        ld_chosen;
      logic        ld_other;
      wr_sel_type  wr;
      out_sel_type out;
      logic        inc_idx;
      logic        inc_col;
      cond_type    cond;
      step_type    jt;
      step_type    jf;
   } ctrl_type;

   function automatic ctrl_type ucode(input step_type step);
      ctrl_type c;
      c = '{busy: 1'b1, rd: 1'b0, asel_row: 1'b0, mul: MUL_NONE, ld_chosen: 1'b0,
            ld_other: 1'b0, wr: WR_NONE, out: OUT_NONE, inc_idx: 1'b0, inc_col: 1'b0,
            cond: COND_ALWAYS, jt: S_IDLE, jf: S_IDLE};
      case (step)
         S_CLR: begin
            c.wr = WR_CLEAR; c.inc_idx = 1'b1;
            c.cond = COND_IDX_MORE; c.jt = S_CLR; c.jf = S_IDLE;
         end
         S_IDLE: begin
            c.busy = 1'b0;
            c.cond = COND_NOT_START; c.jt = S_IDLE; c.jf = S_CHK;
         end
         S_CHK: begin
            c.cond = COND_NO_DECAY; c.jt = S_ADD0; c.jf = S_DRD;
         end
         S_DRD: begin
            c.rd = 1'b1; c.jt = S_DMUL;
         end
         S_DMUL: begin
            c.mul = MUL_DECAY; c.jt = S_DWR;
         end
         S_DWR: begin
            c.wr = WR_DECAY; c.inc_idx = 1'b1;
            c.cond = COND_IDX_MORE; c.jt = S_DRD; c.jf = S_ADD0;
         end
         S_ADD0: begin
            c.mul = MUL_CHOSEN;
            c.cond = COND_BAD_STATE; c.jt = S_IDLE; c.jf = S_ADD1;
         end
         S_ADD1: begin
            c.ld_chosen = 1'b1; c.mul = MUL_OTHER; c.jt = S_ADD2;
         end
         S_ADD2: begin
            c.ld_other = 1'b1; c.jt = S_RRD;
         end
         S_RRD: begin
            c.rd = 1'b1; c.asel_row = 1'b1;
            c.cond = COND_IS_READ; c.jt = S_ROUT; c.jf = S_RWR;
         end
         S_RWR: begin
            c.asel_row = 1'b1; c.wr = WR_ROW; c.out = OUT_SUM; c.inc_col = 1'b1;
            c.cond = COND_COL_MORE; c.jt = S_RRD; c.jf = S_IDLE;
         end
         S_ROUT: begin
            c.out = OUT_RDATA; c.inc_col = 1'b1;
            c.cond = COND_COL_MORE; c.jt = S_RRD; c.jf = S_IDLE;
         end
         default: begin
            c.jt = S_IDLE; c.jf = S_IDLE;
         end
      endcase
      return c;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7fffffff;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: design/propensity_table_reinforce.sv
// Roth-Erev propensity table: one signed Q16.16 entry per state and action.
// An item is taken when start is high and busy is low; its fields sit on the
// req_ ports. Command reinforce adds the payoff shares to the row of the
// given state, after scaling the whole table by keep_factor when the item
// opens an episode. Command read reports the row without change. Each item
// yields one rsp_ beat per action in use (two at least, eight at most), rsp_valid
// high for one cycle each, rsp_last on the final action. The receiver cannot
// stall; beats are not held. A microcoded sequencer drives one table memory
// port, a shared 32x18 multiplier and a saturating adder, one entry at a time.
// A reinforce item and a read item run the steps S_CHK, S_ADD0, S_ADD1
// and S_ADD2, then S_RRD and S_RWR (S_ROUT for a read) per action in use,
// until busy falls; an episode start inserts before S_ADD0 a decay walk of
// read, multiply and write steps (S_DRD, S_DMUL, S_DWR) over all 512 table
// entries. An out-of-range state ends at S_ADD0, after any decay, with no beats.
// Reset restores the csr_ registers to their defaults and clears the table
// with a sweep over all 512 entries, during which busy stays high; csr_ writes are
// taken at any time but belong to idle periods.
module propensity_table_reinforce (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_command,
   input  logic [ptr_pkg::STATE_W-1:0]     req_state_index,
   input  logic [ptr_pkg::COL_W-1:0]       req_action_index,
   input  logic signed [31:0]              req_payoff,
   input  logic                            req_episode_start,
   output logic                            rsp_valid,
   output logic [ptr_pkg::STATE_W-1:0]     rsp_row_state,
   output logic [ptr_pkg::COL_W-1:0]       rsp_column_action,
   output logic signed [31:0]              rsp_propensity,
   output logic                            rsp_last,
   input  logic                            csr_write_enable,
   input  logic [ptr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ptr_pkg::CFG_W-1:0]       csr_write_data
);

   ptr_pkg::step_type step_ff, step_in;
   ptr_pkg::ctrl_type ctrl;

   logic [ptr_pkg::CFG_W-1:0] keep_ff, share_chosen_ff, share_others_ff;
   logic [ptr_pkg::AIU_W-1:0] actions_ff;

   logic                          command_ff;
   logic [ptr_pkg::STATE_W-1:0]   state_ff;
   logic [ptr_pkg::COL_W-1:0]     action_ff;
   logic signed [31:0]            payoff_ff;
   logic                          episode_ff;

   logic [ptr_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic [ptr_pkg::COL_W-1:0]  col_ff, col_in;
   logic [ptr_pkg::COL_W-1:0]  last_col;
   logic [ptr_pkg::ADDR_W-1:0] row_addr, addr;

   logic signed [31:0] mem [ptr_pkg::TABLE_DEPTH];
   logic signed [31:0] rdata_ff;
   logic signed [31:0] wr_data;
   logic               mem_we;

   logic signed [31:0]                mul_a;
   logic [ptr_pkg::CFG_W-1:0]         mul_b;
   logic signed [ptr_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [ptr_pkg::ADD_W-1:0]  prod_shift;
   logic signed [ptr_pkg::ADD_W-1:0]  add_chosen_ff, add_other_ff;
   logic signed [ptr_pkg::SUM_W-1:0]  row_sum;
   logic signed [31:0]                row_value, decay_value;

   logic accept, cond_true, bad_state;

   assign ctrl   = ptr_pkg::ucode(step_ff);
   assign busy   = ctrl.busy;
   assign accept = start && !ctrl.busy;

   always_comb begin
      if (actions_ff < 4'd2) begin
         last_col = ptr_pkg::COL_W'(1);
      end else if (32'(actions_ff) > ptr_pkg::NUM_ACTIONS) begin
         last_col = ptr_pkg::COL_W'(ptr_pkg::NUM_ACTIONS - 1);
      end else begin
         last_col = ptr_pkg::COL_W'(actions_ff - 4'd1);
      end
   end

   assign bad_state = 32'(state_ff) >= ptr_pkg::NUM_STATES;

   always_comb begin
      case (ctrl.cond)
         ptr_pkg::COND_ALWAYS:    cond_true = 1'b1;
         ptr_pkg::COND_NOT_START: cond_true = !start;
         ptr_pkg::COND_NO_DECAY:  cond_true = (command_ff == ptr_pkg::CMD_READ) || !episode_ff;
         ptr_pkg::COND_IDX_MORE:  cond_true = idx_ff != ptr_pkg::ADDR_W'(ptr_pkg::TABLE_DEPTH - 1);
         ptr_pkg::COND_BAD_STATE: cond_true = bad_state;
         ptr_pkg::COND_IS_READ:   cond_true = command_ff == ptr_pkg::CMD_READ;
         ptr_pkg::COND_COL_MORE:  cond_true = col_ff != last_col;
         default:                 cond_true = 1'b1;
      endcase
   end

   always_comb begin
      step_in = cond_true ? ctrl.jt : ctrl.jf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ptr_pkg::S_CLR;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff         <= ptr_pkg::KEEP_FACTOR_RESET;
         share_chosen_ff <= ptr_pkg::SHARE_CHOSEN_RESET;
         share_others_ff <= ptr_pkg::SHARE_OTHERS_RESET;
         actions_ff      <= ptr_pkg::ACTIONS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            ptr_pkg::CSR_KEEP_FACTOR:    keep_ff         <= csr_write_data;
            ptr_pkg::CSR_SHARE_CHOSEN:   share_chosen_ff <= csr_write_data;
            ptr_pkg::CSR_SHARE_OTHERS:   share_others_ff <= csr_write_data;
            ptr_pkg::CSR_ACTIONS_IN_USE: actions_ff      <= csr_write_data[ptr_pkg::AIU_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         command_ff <= req_command;
         state_ff   <= req_state_index;
         action_ff  <= req_action_index;
         payoff_ff  <= req_payoff;
         episode_ff <= req_episode_start;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctrl.inc_idx) begin
         idx_in = (idx_ff == ptr_pkg::ADDR_W'(ptr_pkg::TABLE_DEPTH - 1)) ?
                  '0 : idx_ff + 1'b1;
      end
      col_in = col_ff;
      if (accept) begin
         col_in = '0;
      end else if (ctrl.inc_col) begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         col_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         col_ff <= col_in;
      end
   end

   assign row_addr = ptr_pkg::ADDR_W'(state_ff) * ptr_pkg::ADDR_W'(ptr_pkg::NUM_ACTIONS)
                     + ptr_pkg::ADDR_W'(col_ff);
   assign addr     = ctrl.asel_row ? row_addr : idx_ff;

   always_comb begin
      case (ctrl.mul)
         ptr_pkg::MUL_DECAY:  begin mul_a = rdata_ff;  mul_b = keep_ff;         end
         ptr_pkg::MUL_CHOSEN: begin mul_a = payoff_ff; mul_b = share_chosen_ff; end
         ptr_pkg::MUL_OTHER:  begin mul_a = payoff_ff; mul_b = share_others_ff; end
         default:             begin mul_a = payoff_ff; mul_b = share_others_ff; end
      endcase
   end

   assign prod_in = ptr_pkg::PROD_W'(mul_a) * ptr_pkg::PROD_W'($signed({1'b0, mul_b}));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod_shift  = $signed(prod_ff[ptr_pkg::PROD_W-1:16]);
   assign decay_value = ptr_pkg::sat32(ptr_pkg::SUM_W'(prod_shift));

   always_ff @(posedge clock) begin
      if (ctrl.ld_chosen) begin
         add_chosen_ff <= prod_shift;
      end
      if (ctrl.ld_other) begin
         add_other_ff <= prod_shift;
      end
   end

   assign row_sum   = ptr_pkg::SUM_W'(rdata_ff)
                      + ptr_pkg::SUM_W'((col_ff == action_ff) ? add_chosen_ff : add_other_ff);
   assign row_value = ptr_pkg::sat32(row_sum);

   always_comb begin
      case (ctrl.wr)
         ptr_pkg::WR_CLEAR: begin mem_we = 1'b1; wr_data = '0;          end
         ptr_pkg::WR_DECAY: begin mem_we = 1'b1; wr_data = decay_value; end
         ptr_pkg::WR_ROW:   begin mem_we = 1'b1; wr_data = row_value;   end
         default:           begin mem_we = 1'b0; wr_data = row_value;   end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd) begin
         rdata_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= ctrl.out != ptr_pkg::OUT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out != ptr_pkg::OUT_NONE) begin
         rsp_row_state     <= state_ff;
         rsp_column_action <= col_ff;
         rsp_last          <= col_ff == last_col;
         rsp_propensity    <= (ctrl.out == ptr_pkg::OUT_SUM) ? row_value : rdata_ff;
      end
   end

endmodule
